@@ design/wsfr_pkg.sv @@
// Shared types and constants for the WebSocket frame receiver.
`default_nettype none

package wsfr_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned OPC_W     = 4;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned LEN_W     = 64;
  localparam int unsigned MSG_LEN_W = 32;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned EXT_CNT_W = 4;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned APB_AW    = 3;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;
  localparam logic [EXT_CNT_W-1:0] EXT_BYTES_16 = 4'd2;
  localparam logic [EXT_CNT_W-1:0] EXT_BYTES_64 = 4'd8;

  localparam logic [OPC_W-1:0] OPC_CONT     = 4'd0;
  localparam logic [OPC_W-1:0] OPC_DATA_MAX = 4'd2;
  localparam logic [OPC_W-1:0] OPC_PING     = 4'd9;

  localparam logic [MSG_LEN_W-1:0] MAX_MSG_RESET = 32'd33554432;

  // register index, taken from paddr[2]
  localparam logic REG_MAX_MSG = 1'b0;
  localparam logic REG_CLIENT  = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_BYTE  = 2'd0,
    KIND_END   = 2'd1,
    KIND_PONG  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  typedef struct packed {
    logic [MSG_LEN_W-1:0] max_msg;
    logic                 client_mode;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    kind_e             kind;
    logic [BYTE_W-1:0] data;
    logic [OPC_W-1:0]  opcode;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

@@ design/wsfr_cfg.sv @@
// APB configuration registers of the WebSocket frame receiver.
`default_nettype none

module wsfr_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [wsfr_pkg::APB_AW-1:0]  paddr,
  input  wire logic [wsfr_pkg::APB_DW-1:0]  pwdata,
  output logic      [wsfr_pkg::APB_DW-1:0]  prdata,
  output logic                              pready,
  output wsfr_pkg::cfg_t                    cfg_o
);

  logic [wsfr_pkg::MSG_LEN_W-1:0] max_msg_q;
  logic                           client_q;
  logic                           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_msg_q <= wsfr_pkg::MAX_MSG_RESET;
      client_q  <= 1'b0;
    end else if (wr_en) begin
      if (paddr[2] == wsfr_pkg::REG_MAX_MSG) begin
        max_msg_q <= pwdata[wsfr_pkg::MSG_LEN_W-1:0];
      end else begin
        client_q <= pwdata[0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == wsfr_pkg::REG_MAX_MSG) begin
      prdata = max_msg_q;
    end else begin
      prdata[0] = client_q;
    end
  end

  assign cfg_o.max_msg     = max_msg_q;
  assign cfg_o.client_mode = client_q;

endmodule

`default_nettype wire

@@ design/wsfr_parser.sv @@
// Frame parse state and the per-byte update that yields at most one result.
`default_nettype none

module wsfr_parser (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         go_i,
  input  wire logic [wsfr_pkg::BYTE_W-1:0]  byte_i,
  input  wire wsfr_pkg::cfg_t               cfg_i,
  output wsfr_pkg::res_t                    res_o
);

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_MASK = 3'd3,
    PH_DATA = 3'd4
  } phase_e;

  phase_e                             phase_q, phase_d;
  logic                               closed_q, closed_d;
  logic                               fin_q, fin_d;
  logic [wsfr_pkg::OPC_W-1:0]         opc_q, opc_d;
  logic                               masked_q, masked_d;
  logic [wsfr_pkg::LEN_W-1:0]         len_shift_q, len_shift_d;
  logic [wsfr_pkg::EXT_CNT_W-1:0]     ext_left_q, ext_left_d;
  logic [wsfr_pkg::LEN_W-1:0]         rem_q, rem_d;
  logic [wsfr_pkg::KEY_W-1:0]         key_q, key_d;
  logic [1:0]                         idx_q, idx_d;
  logic [wsfr_pkg::MSG_LEN_W-1:0]     msg_len_q, msg_len_d;
  logic [wsfr_pkg::OPC_W-1:0]         msg_opc_q, msg_opc_d;

  logic                               is_data;
  logic [6:0]                         len_code;
  logic                               do_lk;
  logic                               do_bp;
  logic                               do_pong;
  logic [wsfr_pkg::LEN_W-1:0]         lk_len;
  logic [wsfr_pkg::MSG_LEN_W:0]       lk_sum;
  logic                               lk_over;
  logic [wsfr_pkg::OPC_W-1:0]         cur_opc;
  logic [wsfr_pkg::BYTE_W-1:0]        key_byte;
  logic [wsfr_pkg::BYTE_W-1:0]        plain;
  wsfr_pkg::res_t                     res;

  assign is_data  = (opc_q <= wsfr_pkg::OPC_DATA_MAX);
  assign len_code = byte_i[6:0];

  // message length check: error when running total plus frame length reaches the limit
  assign lk_sum  = {1'b0, msg_len_q} + {1'b0, lk_len[wsfr_pkg::MSG_LEN_W-1:0]};
  assign lk_over = (|lk_len[wsfr_pkg::LEN_W-1:wsfr_pkg::MSG_LEN_W])
                || (lk_sum >= {1'b0, cfg_i.max_msg});

  always_comb begin
    case (idx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  assign plain = masked_q ? (byte_i ^ key_byte) : byte_i;

  always_comb begin
    phase_d     = phase_q;
    closed_d    = closed_q;
    fin_d       = fin_q;
    opc_d       = opc_q;
    masked_d    = masked_q;
    len_shift_d = len_shift_q;
    ext_left_d  = ext_left_q;
    rem_d       = rem_q;
    key_d       = key_q;
    idx_d       = idx_q;
    msg_len_d   = msg_len_q;
    msg_opc_d   = msg_opc_q;
    cur_opc     = msg_opc_q;
    do_lk       = 1'b0;
    do_bp       = 1'b0;
    do_pong     = 1'b0;
    lk_len      = '0;
    res         = '0;
    res.kind    = wsfr_pkg::KIND_BYTE;

    if (!closed_q) begin
      case (phase_q)
        PH_HDR0: begin
          fin_d   = byte_i[7];
          opc_d   = byte_i[wsfr_pkg::OPC_W-1:0];
          phase_d = PH_HDR1;
        end
        PH_HDR1: begin
          masked_d = byte_i[7];
          if (is_data && !cfg_i.client_mode && !byte_i[7]) begin
            closed_d   = 1'b1;
            res.valid  = 1'b1;
            res.kind   = wsfr_pkg::KIND_ERROR;
            res.opcode = msg_opc_q;
          end else begin
            if (is_data && (opc_q != wsfr_pkg::OPC_CONT)
                && (msg_opc_q == wsfr_pkg::OPC_CONT)) begin
              msg_opc_d = opc_q;
              cur_opc   = opc_q;
            end
            len_shift_d = '0;
            if ((len_code == wsfr_pkg::LEN_CODE_16) || (len_code == wsfr_pkg::LEN_CODE_64)) begin
              ext_left_d = (len_code == wsfr_pkg::LEN_CODE_16) ? wsfr_pkg::EXT_BYTES_16
                                                                : wsfr_pkg::EXT_BYTES_64;
              phase_d    = PH_EXT;
            end else begin
              len_shift_d = {{(wsfr_pkg::LEN_W-7){1'b0}}, len_code};
              lk_len      = len_shift_d;
              do_lk       = 1'b1;
            end
            do_pong = (opc_q == wsfr_pkg::OPC_PING);
          end
        end
        PH_EXT: begin
          len_shift_d = {len_shift_q[wsfr_pkg::LEN_W-wsfr_pkg::BYTE_W-1:0], byte_i};
          ext_left_d  = ext_left_q - 1'b1;
          if (ext_left_d == '0) begin
            lk_len = len_shift_d;
            do_lk  = 1'b1;
          end
        end
        PH_MASK: begin
          key_d = {key_q[wsfr_pkg::KEY_W-wsfr_pkg::BYTE_W-1:0], byte_i};
          idx_d = idx_q + 2'd1;
          if (idx_d == 2'd0) begin
            do_bp = 1'b1;
          end
        end
        PH_DATA: begin
          if (masked_q) begin
            idx_d = idx_q + 2'd1;
          end
          rem_d = rem_q - 1'b1;
          if (rem_d == '0) begin
            phase_d = PH_HDR0;
          end
          if (is_data) begin
            res.valid  = 1'b1;
            res.kind   = wsfr_pkg::KIND_BYTE;
            res.data   = plain;
            res.opcode = msg_opc_q;
            res.last   = (rem_d == '0) && fin_q;
            if ((rem_d == '0) && fin_q) begin
              msg_len_d = '0;
              msg_opc_d = wsfr_pkg::OPC_CONT;
            end
          end
        end
        default: begin
          phase_d = PH_HDR0;
        end
      endcase

      if (do_lk) begin
        if (is_data && lk_over) begin
          closed_d   = 1'b1;
          res.valid  = 1'b1;
          res.kind   = wsfr_pkg::KIND_ERROR;
          res.opcode = cur_opc;
        end else begin
          if (is_data) begin
            msg_len_d = lk_sum[wsfr_pkg::MSG_LEN_W-1:0];
          end
          rem_d = lk_len;
          if (masked_d) begin
            phase_d = PH_MASK;
            key_d   = '0;
            idx_d   = 2'd0;
          end else begin
            do_bp = 1'b1;
          end
        end
      end

      if (do_bp) begin
        if (rem_d != '0) begin
          phase_d = PH_DATA;
        end else begin
          phase_d = PH_HDR0;
          if (is_data && fin_q) begin
            res.valid  = 1'b1;
            res.kind   = wsfr_pkg::KIND_END;
            res.opcode = cur_opc;
            res.last   = 1'b1;
            msg_len_d  = '0;
            msg_opc_d  = wsfr_pkg::OPC_CONT;
          end
        end
      end

      if (do_pong) begin
        res.valid  = 1'b1;
        res.kind   = wsfr_pkg::KIND_PONG;
        res.data   = '0;
        res.opcode = cur_opc;
        res.last   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HDR0;
      closed_q    <= 1'b0;
      fin_q       <= 1'b0;
      opc_q       <= '0;
      masked_q    <= 1'b0;
      len_shift_q <= '0;
      ext_left_q  <= '0;
      rem_q       <= '0;
      key_q       <= '0;
      idx_q       <= 2'd0;
      msg_len_q   <= '0;
      msg_opc_q   <= '0;
    end else if (go_i) begin
      phase_q     <= phase_d;
      closed_q    <= closed_d;
      fin_q       <= fin_d;
      opc_q       <= opc_d;
      masked_q    <= masked_d;
      len_shift_q <= len_shift_d;
      ext_left_q  <= ext_left_d;
      rem_q       <= rem_d;
      key_q       <= key_d;
      idx_q       <= idx_d;
      msg_len_q   <= msg_len_d;
      msg_opc_q   <= msg_opc_d;
    end
  end

  assign res_o = res;

endmodule

`default_nettype wire

@@ design/websocket_frame_receiver.sv @@
// Top level of the WebSocket frame receiver: input register, parser, result register.
//
//   channel  direction  handshake                 payload
//   in       in         in_valid_i / in_stall_o   in_byte_i
//   out      out        out_valid_o / out_stall_i out_kind_o, payload_byte_o,
//                                                  msg_opcode_o, msg_last_o
//   cfg      in         APB psel/penable/pready   paddr, pwdata, prdata
//
// One byte per cycle sustained while out_stall_i is low; results are registered.
// The parser state advances when the input register holds a byte and the result
// register is empty or being read out in the same cycle.
// Reset clears parse state and loads configuration defaults.
// A stall on the output backs up into in_stall_o once the input register is full.
`default_nettype none

module websocket_frame_receiver (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [wsfr_pkg::BYTE_W-1:0]  in_byte_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic      [wsfr_pkg::KIND_W-1:0]  out_kind_o,
  output logic      [wsfr_pkg::BYTE_W-1:0]  payload_byte_o,
  output logic      [wsfr_pkg::OPC_W-1:0]   msg_opcode_o,
  output logic                              msg_last_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [wsfr_pkg::APB_AW-1:0]  paddr,
  input  wire logic [wsfr_pkg::APB_DW-1:0]  pwdata,
  output logic      [wsfr_pkg::APB_DW-1:0]  prdata,
  output logic                              pready
);

  wsfr_pkg::cfg_t              cfg;
  wsfr_pkg::res_t              res;
  logic                        in_valid_q;
  logic [wsfr_pkg::BYTE_W-1:0] in_byte_q;
  logic                        out_valid_q;
  wsfr_pkg::res_t              out_q;
  logic                        go;

  assign go         = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !go;

  wsfr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  wsfr_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go),
    .byte_i (in_byte_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= in_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (go) begin
      out_valid_q <= res.valid;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && res.valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_kind_o     = out_q.kind;
  assign payload_byte_o = out_q.data;
  assign msg_opcode_o   = out_q.opcode;
  assign msg_last_o     = out_q.last;

endmodule

`default_nettype wire
